// ===== rtl/mfs_pkg.sv =====
// Shared types, constants and helpers for the multilevel feedback scheduler.
package mfs_pkg;

    localparam int NUM_LEVELS_DEF  = 4;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF    = 8;

    localparam int PID_W     = 8;
    localparam int LEVEL_W   = 2;
    localparam int QUANTUM_W = 3;

    localparam int LVL_MAX_W = 3;
    localparam int PID_MAX_W = 16;

    localparam int QUANTUM_CAP_LEVEL = 3;
    localparam logic [QUANTUM_W-1:0] QUANTUM_MAX = 3'd7;

    typedef enum logic {
        REQ_ADMIT = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_t;

    typedef struct packed {
        logic                 push_en;
        logic [LVL_MAX_W-1:0] push_lvl;
        logic [PID_MAX_W-1:0] push_pid;
        logic                 pop_en;
    } q_req_t;

    typedef struct packed {
        logic                 push_full;
        logic                 disp_valid;
        logic [LVL_MAX_W-1:0] disp_lvl;
        logic [PID_MAX_W-1:0] disp_pid;
    } q_status_t;

    function automatic logic [QUANTUM_W-1:0] quantum_for(input int lvl);
        logic [QUANTUM_W-1:0] q;
        if (lvl >= QUANTUM_CAP_LEVEL) begin
            q = QUANTUM_MAX;
        end else begin
            q = QUANTUM_W'((1 << lvl) - 1);
        end
        return q;
    endfunction

endpackage

// ===== rtl/mfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mfs_queues.sv =====
// Per-level pid FIFOs with head registers, a shared RAM and the dispatch priority encoder.
module mfs_queues
    import mfs_pkg::*;
#(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_req_t    req,
    output q_status_t status
);

    localparam int LVL_BITS  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SLOT_BITS = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int SUM_BITS  = SLOT_BITS + 1;
    localparam int CNT_BITS  = $clog2(LEVEL_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [SLOT_BITS-1:0] head_slot_reg [NUM_LEVELS];
    logic [SLOT_BITS-1:0] head_slot_next [NUM_LEVELS];
    logic [CNT_BITS-1:0]  count_reg [NUM_LEVELS];
    logic [CNT_BITS-1:0]  count_next [NUM_LEVELS];
    logic [PID_BITS-1:0]  head_pid_reg [NUM_LEVELS];
    logic [PID_BITS-1:0]  head_pid_next [NUM_LEVELS];
    logic                 fill_pending_reg;
    logic                 fill_pending_next;
    logic [LVL_BITS-1:0]  fill_lvl_reg;
    logic [LVL_BITS-1:0]  fill_lvl_next;

    logic [PID_BITS-1:0]  eff_head [NUM_LEVELS];
    logic [CNT_BITS-1:0]  cnt_post [NUM_LEVELS];

    logic [LVL_BITS-1:0]  push_lvl;
    logic [PID_BITS-1:0]  push_pid;
    logic                 push_full;
    logic                 push_ok;
    logic                 disp_found;
    logic [LVL_BITS-1:0]  disp_lvl;
    logic [PID_BITS-1:0]  disp_pid;
    logic                 pop_ok;
    logic                 need_fill;

    logic [SUM_BITS-1:0]  wsum;
    logic [SLOT_BITS-1:0] wslot;
    logic [SLOT_BITS-1:0] next_slot;
    logic [ADDR_BITS-1:0] waddr;
    logic [ADDR_BITS-1:0] raddr;
    logic [PID_BITS-1:0]  rdata;

    assign push_lvl  = req.push_lvl[LVL_BITS-1:0];
    assign push_pid  = req.push_pid[PID_BITS-1:0];
    assign push_full = (count_reg[push_lvl] == CNT_BITS'(LEVEL_DEPTH));
    assign push_ok   = req.push_en && !push_full;

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            eff_head[l] = (fill_pending_reg && (fill_lvl_reg == LVL_BITS'(l))) ?
                          rdata : head_pid_reg[l];
            cnt_post[l] = count_reg[l] +
                          CNT_BITS'(push_ok && (push_lvl == LVL_BITS'(l)));
        end
    end

    always_comb begin
        disp_found = 1'b0;
        disp_lvl   = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (!disp_found && (cnt_post[l] != '0)) begin
                disp_found = 1'b1;
                disp_lvl   = LVL_BITS'(l);
            end
        end
    end

    // The pushed pid passes straight through when its level was empty.
    assign disp_pid = (push_ok && (push_lvl == disp_lvl) && (count_reg[disp_lvl] == '0)) ?
                      push_pid : eff_head[disp_lvl];
    assign pop_ok    = req.pop_en && disp_found;
    assign need_fill = pop_ok && (count_reg[disp_lvl] >= CNT_BITS'(2));

    assign wsum  = SUM_BITS'(head_slot_reg[push_lvl]) + SUM_BITS'(count_reg[push_lvl]);
    assign wslot = (wsum >= SUM_BITS'(LEVEL_DEPTH)) ?
                   SLOT_BITS'(wsum - SUM_BITS'(LEVEL_DEPTH)) : SLOT_BITS'(wsum);
    assign next_slot = (head_slot_reg[disp_lvl] == SLOT_BITS'(LEVEL_DEPTH - 1)) ?
                       '0 : head_slot_reg[disp_lvl] + SLOT_BITS'(1);
    assign waddr = ADDR_BITS'(int'(push_lvl) * LEVEL_DEPTH + int'(wslot));
    assign raddr = ADDR_BITS'(int'(disp_lvl) * LEVEL_DEPTH + int'(next_slot));

    always_comb begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
            count_next[l]     = cnt_post[l] -
                                CNT_BITS'(pop_ok && (disp_lvl == LVL_BITS'(l)));
            head_slot_next[l] = (pop_ok && (disp_lvl == LVL_BITS'(l))) ?
                                next_slot : head_slot_reg[l];
            head_pid_next[l]  = eff_head[l];
            if (push_ok && (push_lvl == LVL_BITS'(l)) &&
                ((count_reg[l] == '0) ||
                 ((count_reg[l] == CNT_BITS'(1)) && pop_ok &&
                  (disp_lvl == LVL_BITS'(l))))) begin
                head_pid_next[l] = push_pid;
            end
        end
        fill_pending_next = need_fill;
        fill_lvl_next     = disp_lvl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                count_reg[l]     <= '0;
                head_slot_reg[l] <= '0;
            end
            fill_pending_reg <= 1'b0;
        end else begin
            count_reg        <= count_next;
            head_slot_reg    <= head_slot_next;
            fill_pending_reg <= fill_pending_next;
        end
        head_pid_reg <= head_pid_next;
        fill_lvl_reg <= fill_lvl_next;
    end

    mfs_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (push_ok),
        .waddr (waddr),
        .wdata (push_pid),
        .re    (need_fill),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.push_full  = push_full;
    assign status.disp_valid = disp_found;
    assign status.disp_lvl   = LVL_MAX_W'(disp_lvl);
    assign status.disp_pid   = PID_MAX_W'(disp_pid);

    // A pending head refill always targets a level that still holds entries.
    a_fill_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_pending_reg |-> (count_reg[fill_lvl_reg] != '0))
        else $error("head refill pending on an empty level");

    // A successful push leaves its level non-empty.
    a_push_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (push_ok && !pop_ok) |=> (count_reg[$past(push_lvl)] != '0))
        else $error("level empty after push");

    // A lone pop lowers the count of its level by exactly one.
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop_ok && !push_ok) |=>
        (count_reg[$past(disp_lvl)] == $past(count_reg[disp_lvl]) - CNT_BITS'(1)))
        else $error("pop did not lower level count by one");

endmodule

// ===== rtl/multilevel_feedback_scheduler_core.sv =====
// Top level: running-process control, admit/tick decoding and the result register.
// The result of an item is registered and shown in the cycle after it is accepted.
// Throughput: one admit or tick item per cycle, sustained; the input stalls only while a result waits.
// A dispatch reads the head register of the chosen level; the RAM refills it in the cycle after the dispatch.
// Reset is synchronous and active low: all level queues empty, no process running, no result.
// The pid store is not cleared by reset; entries are only read after they are written.
module multilevel_feedback_scheduler_core
    import mfs_pkg::*;
#(
    parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
    parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
    parameter int PID_BITS    = PID_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [PID_W-1:0]     s_proc_id,
    input  logic [LEVEL_W-1:0]   s_admit_level,
    input  logic                 s_run_done,
    input  logic                 s_run_blocked,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_run_valid,
    output logic [PID_W-1:0]     m_run_pid,
    output logic [LEVEL_W-1:0]   m_run_level,
    output logic [QUANTUM_W-1:0] m_quantum_left,
    output logic                 m_new_dispatch,
    output logic [LEVEL_W-1:0]   m_outgoing_level,
    output logic                 m_queue_overflow
);

    localparam int LVL_BITS = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    logic                 present_reg, present_next;
    logic [PID_BITS-1:0]  run_id_reg, run_id_next;
    logic [LVL_BITS-1:0]  run_lvl_reg, run_lvl_next;
    logic [QUANTUM_W-1:0] quantum_reg, quantum_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_run_valid_reg;
    logic [PID_W-1:0]     m_run_pid_reg;
    logic [LEVEL_W-1:0]   m_run_level_reg;
    logic [QUANTUM_W-1:0] m_quantum_left_reg;
    logic                 m_new_dispatch_reg;
    logic [LEVEL_W-1:0]   m_outgoing_level_reg;
    logic                 m_queue_overflow_reg;

    logic                 accept;
    logic                 is_tick;
    logic [LVL_BITS-1:0]  in_lvl;
    logic [LVL_BITS-1:0]  demoted_lvl;
    logic                 leave;
    logic                 stay;
    logic [LVL_BITS-1:0]  out_lvl;
    logic                 new_disp;
    logic                 ovf;
    logic [LVL_BITS-1:0]  disp_lvl;

    q_req_t               q_req;
    q_status_t            q_status;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_tick = (s_req_type == REQ_TICK);

    assign in_lvl = (int'(s_admit_level) > NUM_LEVELS - 1) ?
                    LVL_BITS'(NUM_LEVELS - 1) : LVL_BITS'(s_admit_level);
    assign demoted_lvl = (int'(run_lvl_reg) < NUM_LEVELS - 1) ?
                         run_lvl_reg + LVL_BITS'(1) : run_lvl_reg;
    assign disp_lvl = q_status.disp_lvl[LVL_BITS-1:0];

    always_comb begin
        q_req.push_en  = 1'b0;
        q_req.push_lvl = LVL_MAX_W'(in_lvl);
        q_req.push_pid = PID_MAX_W'(PID_BITS'(s_proc_id));
        leave          = 1'b0;
        stay           = 1'b0;
        out_lvl        = '0;
        if (!is_tick) begin
            q_req.push_en = accept;
        end else if (!present_reg) begin
            leave = 1'b1;
        end else begin
            priority if (s_run_done) begin
                out_lvl = run_lvl_reg;
                leave   = 1'b1;
            end else if (quantum_reg == '0) begin
                out_lvl        = demoted_lvl;
                leave          = 1'b1;
                q_req.push_en  = accept && !s_run_blocked;
                q_req.push_lvl = LVL_MAX_W'(demoted_lvl);
                q_req.push_pid = PID_MAX_W'(run_id_reg);
            end else if (s_run_blocked) begin
                out_lvl = run_lvl_reg;
                leave   = 1'b1;
            end else begin
                stay = 1'b1;
            end
        end
        q_req.pop_en = accept && leave;
    end

    assign new_disp = leave && q_status.disp_valid;
    assign ovf      = q_req.push_en && q_status.push_full;

    always_comb begin
        present_next = present_reg;
        run_id_next  = run_id_reg;
        run_lvl_next = run_lvl_reg;
        quantum_next = quantum_reg;
        if (accept && is_tick) begin
            if (stay) begin
                quantum_next = quantum_reg - QUANTUM_W'(1);
            end else if (q_status.disp_valid) begin
                present_next = 1'b1;
                run_id_next  = q_status.disp_pid[PID_BITS-1:0];
                run_lvl_next = disp_lvl;
                quantum_next = quantum_for(int'(disp_lvl));
            end else begin
                present_next = 1'b0;
                run_id_next  = '0;
                run_lvl_next = '0;
                quantum_next = '0;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            run_id_reg  <= '0;
            run_lvl_reg <= '0;
            quantum_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            present_reg <= present_next;
            run_id_reg  <= run_id_next;
            run_lvl_reg <= run_lvl_next;
            quantum_reg <= quantum_next;
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            m_run_valid_reg      <= present_next;
            m_run_pid_reg        <= PID_W'(run_id_next);
            m_run_level_reg      <= LEVEL_W'(run_lvl_next);
            m_quantum_left_reg   <= quantum_next;
            m_new_dispatch_reg   <= is_tick && new_disp;
            m_outgoing_level_reg <= LEVEL_W'(out_lvl);
            m_queue_overflow_reg <= ovf;
        end
    end

    mfs_queues #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_queues (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (q_req),
        .status  (q_status)
    );

    assign m_valid          = m_valid_reg;
    assign m_run_valid      = m_run_valid_reg;
    assign m_run_pid        = m_run_pid_reg;
    assign m_run_level      = m_run_level_reg;
    assign m_quantum_left   = m_quantum_left_reg;
    assign m_new_dispatch   = m_new_dispatch_reg;
    assign m_outgoing_level = m_outgoing_level_reg;
    assign m_queue_overflow = m_queue_overflow_reg;

    // With no process running, the running-process registers hold zero.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !present_reg |-> ((run_id_reg == '0) && (run_lvl_reg == '0) && (quantum_reg == '0)))
        else $error("idle scheduler holds stale running state");

    // An accepted item always leaves a result in the output register.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("accepted item produced no result");

    // A new dispatch is always reported together with a running process.
    a_dispatch_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_new_dispatch_reg) |-> m_run_valid_reg)
        else $error("dispatch reported without a running process");

endmodule
